FILE: hw/rtl/csl_pkg.sv
// package for the c subset lexer: token kinds, attributes, scanner states
// no dependencies
`default_nettype none
package csl_pkg;
    localparam logic [2:0] K_ID = 3'd0, K_KEY = 3'd1, K_CONST = 3'd2, K_OP = 3'd3,
        K_BOUND = 3'd4, K_BRACKET = 3'd5, K_FAIL = 3'd6, K_DONE = 3'd7;
    localparam logic [4:0] A_NONE = 5'd0, A_ID = 5'd8, A_CONST = 5'd9;
    localparam logic [4:0] A_PLUS = 5'd10, A_MINUS = 5'd11, A_STAR = 5'd12,
        A_SLASH = 5'd13, A_ASSIGN = 5'd14, A_EQ = 5'd15, A_GT = 5'd16, A_GE = 5'd17,
        A_LT = 5'd18, A_LE = 5'd19, A_NE = 5'd20, A_AND = 5'd21, A_OR = 5'd22,
        A_COMMA = 5'd23, A_SEMI = 5'd24, A_LBRACE = 5'd25, A_RBRACE = 5'd26,
        A_LPAREN = 5'd27, A_RPAREN = 5'd28, A_LBRACK = 5'd29, A_RBRACK = 5'd30;
    localparam logic [3:0] S_IDLE = 4'd0, S_IDENT = 4'd1, S_INT = 4'd2, S_FRAC = 4'd3,
        S_EXPMARK = 4'd4, S_EXPMINUS = 4'd5, S_EXP = 4'd6, S_EQ = 4'd7, S_GT = 4'd8,
        S_LT = 4'd9, S_BANG = 4'd10, S_AMP = 4'd11, S_BAR = 4'd12;

    // classified character, passed from front to back
    typedef struct packed {
        logic [7:0] ch;
        logic       done;
        logic       letter;
        logic       digit;
        logic       blank;
    } char_class_t;

    function automatic char_class_t classify(input logic [7:0] c, input logic d);
        char_class_t r;
        r.ch = c;
        r.done = d;
        r.letter = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
        r.digit = (c >= 8'h30 && c <= 8'h39);
        r.blank = (c == 8'h20) || (c == 8'h0a);
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/csl_if.sv
// valid/ready channel interface with parametrised payload
// depends on nothing
`default_nettype none
interface csl_if #(parameter int W = 8) (input wire logic clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/csl_front.sv
// front end: accepts characters, classifies them, two-entry queue to the back
// depends on csl_pkg
`default_nettype none
module csl_front
    import csl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_ch,
    input  wire logic       in_end,
    output logic            q_valid,
    input  wire logic       q_ready,
    output char_class_t     q_data
);
    char_class_t mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_data = mem_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= classify(in_ch, in_end);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/csl_back.sv
// back end: scanner state machine, emits up to two tokens per character
// depends on csl_pkg
`default_nettype none
module csl_back
    import csl_pkg::*;
#(
    parameter int KEYWORD_CHARS = 6,
    parameter int LENGTH_BITS = 8,
    parameter int POSITION_BITS = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     q_valid,
    output logic                          q_ready,
    input  char_class_t                   q_data,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [2:0]                    out_kind,
    output logic [4:0]                    out_attr,
    output logic [LENGTH_BITS-1:0]        out_length,
    output logic [POSITION_BITS-1:0]      out_row,
    output logic [POSITION_BITS-1:0]      out_column,
    output logic                          out_last
);
    localparam int LW = LENGTH_BITS;
    localparam int PW = POSITION_BITS;
    localparam int TW = 3 + 5 + LW + PW + PW;
    localparam logic [LW-1:0] LEN_MAX = {LW{1'b1}};
    localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

    logic [3:0]                 st_reg, st_next;
    logic [8*KEYWORD_CHARS-1:0] lead_reg, lead_next;
    logic [LW-1:0]              len_reg, len_next;
    logic [PW-1:0]              row_reg, row_next, col_reg, col_next;
    logic                       fin_reg, fin_next;

    // output slots: first token and second token
    logic          v0_reg, v1_reg, l0_reg;
    logic [TW-1:0] t0_reg, t1_reg;
    logic          n0, n1;
    logic [TW-1:0] tk0, tk1;
    logic          step;

    logic [7:0] c;
    assign c = q_data.ch;

    // output side: slot 0 shown, slot 1 follows it
    assign out_valid = v0_reg;
    assign {out_kind, out_attr, out_length, out_row, out_column} = t0_reg;
    assign out_last = l0_reg;
    logic drain;
    assign drain = v0_reg && out_ready;
    // accept when slot 1 empty and slot 0 empty or leaving
    assign q_ready = !v1_reg && (!v0_reg || out_ready);
    assign step = q_valid && q_ready;

    function automatic logic [4:0] kw_attr(input logic [8*KEYWORD_CHARS-1:0] lc,
                                           input logic [LW-1:0] ln);
        logic [4:0] a;
        a = 5'd0;
        if (ln == LW'(3) && lc[23:0] == 24'h746e69) a = 5'd1;
        else if (ln == LW'(5) && lc[39:0] == 40'h74616f6c66) a = 5'd2;
        else if (ln == LW'(4) && lc[31:0] == 32'h64696f76) a = 5'd3;
        else if (ln == LW'(2) && lc[15:0] == 16'h6669) a = 5'd4;
        else if (ln == LW'(4) && lc[31:0] == 32'h65736c65) a = 5'd5;
        else if (ln == LW'(5) && lc[39:0] == 40'h656c696877) a = 5'd6;
        else if (ln == LW'(6) && lc[47:0] == 48'h6e7275746572) a = 5'd7;
        return a;
    endfunction

    always_comb
    begin
        logic grow, fin, ftake, flush_it, bad;
        logic [3:0] st;
        logic [4:0] fattr, kw, iattr;
        logic [2:0] fk, ikind;
        logic [8*KEYWORD_CHARS-1:0] lead1;
        logic [LW-1:0] len1;
        logic [PW-1:0] col1;
        logic [3:0] nst;

        st_next = st_reg;
        lead_next = lead_reg;
        len_next = len_reg;
        row_next = row_reg;
        col_next = col_reg;
        fin_next = fin_reg;
        n0 = 1'b0;
        n1 = 1'b0;
        tk0 = '0;
        tk1 = '0;
        grow = 1'b0;
        fin = 1'b0;
        ftake = 1'b0;
        flush_it = 1'b0;
        bad = 1'b0;
        st = st_reg;
        fattr = A_NONE;
        kw = kw_attr(lead_reg, len_reg);
        fk = K_FAIL;
        iattr = A_NONE;
        ikind = K_OP;
        nst = S_IDLE;
        col1 = (col_reg != POS_MAX) ? col_reg + PW'(1) : col_reg;
        lead1 = lead_reg;
        for (int i = 0; i < KEYWORD_CHARS; i++)
        begin
            if (len_reg == LW'(i))
            begin
                lead1[8*i +: 8] = c;
            end
        end
        len1 = (len_reg != LEN_MAX) ? len_reg + LW'(1) : len_reg;

        // token flushed by a non-matching character
        case (st_reg)
            S_IDENT:
            begin
                fk = (kw != 5'd0) ? K_KEY : K_ID;
                fattr = (kw != 5'd0) ? kw : A_ID;
            end
            S_INT, S_FRAC, S_EXP:
            begin
                fk = K_CONST;
                fattr = A_CONST;
            end
            S_EQ:
            begin
                fk = K_OP;
                fattr = A_ASSIGN;
            end
            S_GT:
            begin
                fk = K_OP;
                fattr = A_GT;
            end
            S_LT:
            begin
                fk = K_OP;
                fattr = A_LT;
            end
            default:
            begin
                fk = K_FAIL;
                fattr = A_NONE;
            end
        endcase

        if (fin_reg)
        begin
            n0 = 1'b1;
            tk0 = {K_DONE, A_NONE, LW'(0), row_reg, col_reg};
        end
        else if (q_data.done)
        begin
            fin_next = 1'b1;
            st_next = S_IDLE;
            lead_next = '0;
            len_next = '0;
            if (st_reg != S_IDLE)
            begin
                n0 = 1'b1;
                tk0 = {fk, fattr, len_reg, row_reg, col_reg};
                n1 = 1'b1;
                tk1 = {K_DONE, A_NONE, LW'(0), row_reg, col_reg};
            end
            else
            begin
                n0 = 1'b1;
                tk0 = {K_DONE, A_NONE, LW'(0), row_reg, col_reg};
            end
        end
        else
        begin
            case (st_reg)
                S_IDENT: grow = q_data.letter || q_data.digit;
                S_INT:
                begin
                    if (q_data.digit) grow = 1'b1;
                    else if (c == 8'h2e)
                    begin
                        grow = 1'b1;
                        st = S_FRAC;
                    end
                end
                S_FRAC:
                begin
                    if (q_data.digit) grow = 1'b1;
                    else if (c == 8'h65 || c == 8'h45)
                    begin
                        grow = 1'b1;
                        st = S_EXPMARK;
                    end
                end
                S_EXPMARK:
                begin
                    if (c == 8'h2d)
                    begin
                        grow = 1'b1;
                        st = S_EXPMINUS;
                    end
                    else if (q_data.digit)
                    begin
                        grow = 1'b1;
                        st = S_EXP;
                    end
                    else ftake = !q_data.blank;
                end
                S_EXPMINUS:
                begin
                    if (q_data.digit)
                    begin
                        grow = 1'b1;
                        st = S_EXP;
                    end
                    else ftake = !q_data.blank;
                end
                S_EXP: grow = q_data.digit;
                S_EQ:
                begin
                    fin = (c == 8'h3d);
                    iattr = A_EQ;
                end
                S_GT:
                begin
                    fin = (c == 8'h3d);
                    iattr = A_GE;
                end
                S_LT:
                begin
                    fin = (c == 8'h3d);
                    iattr = A_LE;
                end
                S_BANG:
                begin
                    fin = (c == 8'h3d);
                    iattr = A_NE;
                    ftake = !fin && !q_data.blank;
                end
                S_AMP:
                begin
                    fin = (c == 8'h26);
                    iattr = A_AND;
                    ftake = !fin && !q_data.blank;
                end
                S_BAR:
                begin
                    fin = (c == 8'h7c);
                    iattr = A_OR;
                    ftake = !fin && !q_data.blank;
                end
                default: grow = 1'b0;
            endcase

            if (grow)
            begin
                col_next = col1;
                lead_next = lead1;
                len_next = len1;
                st_next = st;
            end
            else if (fin || ftake)
            begin
                col_next = col1;
                n0 = 1'b1;
                tk0 = {fin ? K_OP : K_FAIL, fin ? iattr : A_NONE, len1, row_reg, col1};
                st_next = S_IDLE;
                lead_next = '0;
                len_next = '0;
            end
            else
            begin
                flush_it = (st_reg != S_IDLE);
                // idle scan of c
                ikind = K_OP;
                iattr = A_NONE;
                nst = S_IDLE;
                if (c == 8'h0a)
                begin
                    row_next = (row_reg != POS_MAX) ? row_reg + PW'(1) : row_reg;
                    col_next = '0;
                end
                else
                begin
                    col_next = col1;
                    if (q_data.letter) nst = S_IDENT;
                    else if (q_data.digit) nst = S_INT;
                    else
                    begin
                        case (c)
                            8'h20: nst = S_IDLE;
                            8'h3d: nst = S_EQ;
                            8'h3e: nst = S_GT;
                            8'h3c: nst = S_LT;
                            8'h21: nst = S_BANG;
                            8'h26: nst = S_AMP;
                            8'h7c: nst = S_BAR;
                            8'h2b: iattr = A_PLUS;
                            8'h2d: iattr = A_MINUS;
                            8'h2a: iattr = A_STAR;
                            8'h2f: iattr = A_SLASH;
                            8'h2c: {ikind, iattr} = {K_BOUND, A_COMMA};
                            8'h3b: {ikind, iattr} = {K_BOUND, A_SEMI};
                            8'h7b: {ikind, iattr} = {K_BRACKET, A_LBRACE};
                            8'h7d: {ikind, iattr} = {K_BRACKET, A_RBRACE};
                            8'h28: {ikind, iattr} = {K_BRACKET, A_LPAREN};
                            8'h29: {ikind, iattr} = {K_BRACKET, A_RPAREN};
                            8'h5b: {ikind, iattr} = {K_BRACKET, A_LBRACK};
                            8'h5d: {ikind, iattr} = {K_BRACKET, A_RBRACK};
                            default: {ikind, iattr} = {K_FAIL, A_NONE};
                        endcase
                        bad = (c != 8'h20) && (nst == S_IDLE);
                    end
                end
                st_next = nst;
                if (nst != S_IDLE)
                begin
                    lead_next = '0;
                    lead_next[7:0] = c;
                    len_next = LW'(1);
                end
                else
                begin
                    lead_next = '0;
                    len_next = '0;
                end
                if (flush_it)
                begin
                    n0 = 1'b1;
                    tk0 = {fk, fattr, len_reg, row_reg, col_reg};
                    n1 = bad;
                    tk1 = {ikind, iattr, LW'(1), row_reg, col_next};
                end
                else
                begin
                    n0 = bad;
                    tk0 = {ikind, iattr, LW'(1), row_reg, col_next};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            t0_reg <= n0 ? tk0 : t0_reg;
            t1_reg <= tk1;
            l0_reg <= !n1;
        end
        else if (drain && v1_reg)
        begin
            t0_reg <= t1_reg;
            l0_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            lead_reg <= '0;
            len_reg <= '0;
            row_reg <= '0;
            col_reg <= '0;
            fin_reg <= 1'b0;
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                st_reg <= st_next;
                lead_reg <= lead_next;
                len_reg <= len_next;
                row_reg <= row_next;
                col_reg <= col_next;
                fin_reg <= fin_next;
                v0_reg <= n0 || (v0_reg && !out_ready);
                v1_reg <= n1;
            end
            else if (drain)
            begin
                v0_reg <= v1_reg;
                v1_reg <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/c_subset_lexer.sv
// top level of the c subset lexer: front classifier, queue, back scanner
// path: a character is registered in the front queue, then its token in a scanner output slot
// throughput: one character per cycle while the output takes tokens; a character giving
// two tokens holds the input until its second token leaves slot 1 of the scanner
// reset: asynchronous, active low; scanner idle, counters zero, no token pending
// depends on csl_pkg, csl_if, csl_front, csl_back
`default_nettype none
module c_subset_lexer
    import csl_pkg::*;
#(
    parameter int KEYWORD_CHARS = 6,
    parameter int LENGTH_BITS = 8,
    parameter int POSITION_BITS = 16
)
(
    input wire logic clk,
    input wire logic rst_n,
    csl_if.sink      in_chan,
    csl_if.source    out_chan
);
    localparam int OW = 3 + 5 + LENGTH_BITS + 2 * POSITION_BITS + 1;
    logic        q_valid, q_ready;
    char_class_t q_data;
    logic [2:0]  kind;
    logic [4:0]  attr;
    logic [LENGTH_BITS-1:0]   len;
    logic [POSITION_BITS-1:0] row, col;
    logic        last;

    csl_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_chan.valid), .in_ready(in_chan.ready),
        .in_ch(in_chan.data[8:1]), .in_end(in_chan.data[0]),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    csl_back #(
        .KEYWORD_CHARS(KEYWORD_CHARS), .LENGTH_BITS(LENGTH_BITS),
        .POSITION_BITS(POSITION_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .out_valid(out_chan.valid), .out_ready(out_chan.ready),
        .out_kind(kind), .out_attr(attr), .out_length(len),
        .out_row(row), .out_column(col), .out_last(last)
    );

    assign out_chan.data = OW'({kind, attr, len, row, col, last});
endmodule
`default_nettype wire
